FILE: rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [6:0] PadIndex = 7'h40;
  localparam logic [6:0] CharUpperA = 7'h41;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam logic [6:0] CharZero = 7'h30;
  localparam logic [6:0] CharPlus = 7'h2B;
  localparam logic [6:0] CharSlash = 7'h2F;
  localparam logic [6:0] CharPad = 7'h3D;

  // One group of up to three bytes, left aligned, low bytes zero filled.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  have;   // bytes in the group, 1..3
    logic        last;
  } group_t;

  // Alphabet index (0..63, or the pad index) to ASCII.
  function automatic logic [6:0] b64_char(input logic [6:0] idx);
    logic [6:0] c;
    if (idx < 7'd26) begin
      c = CharUpperA + idx;
    end else if (idx < 7'd52) begin
      c = CharLowerA + (idx - 7'd26);
    end else if (idx < 7'd62) begin
      c = CharZero + (idx - 7'd52);
    end else if (idx == 7'd62) begin
      c = CharPlus;
    end else if (idx == 7'd63) begin
      c = CharSlash;
    end else begin
      c = CharPad;
    end
    return c;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                q_full,
  output logic                in_ready,
  output logic                push,
  output b64e_pkg::group_t    push_group
);

  logic [15:0] held_bytes;
  logic [1:0]  group_count;
  logic [1:0]  have;
  logic        accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign have = group_count + 2'd1;
  assign push = accept && (have == 2'd3 || in_last);

  always_comb begin
    push_group.have = have;
    push_group.last = in_last;
    case (have)
      2'd1: push_group.word = {in_byte, 16'h0000};
      2'd2: push_group.word = {held_bytes[7:0], in_byte, 8'h00};
      default: push_group.word = {held_bytes, in_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      group_count <= '0;
    end else if (accept) begin
      if (push) begin
        held_bytes <= '0;
        group_count <= '0;
      end else begin
        held_bytes <= {held_bytes[7:0], in_byte};
        group_count <= have;
      end
    end
  end

endmodule

FILE: rtl/b64e_fifo.sv
module b64e_fifo #(
  parameter int unsigned DEPTH = b64e_pkg::FifoDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64e_pkg::group_t  push_group,
  input  logic              pop,
  output b64e_pkg::group_t  head,
  output logic              empty,
  output logic              full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  b64e_pkg::group_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CW'(DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back (
  input  logic              clk,
  input  logic              rst,
  input  b64e_pkg::group_t  head,
  input  logic              q_empty,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [6:0]        out_char,
  output logic              out_last
);

  b64e_pkg::group_t cur;
  logic       cur_valid;
  logic [1:0] k;
  logic       adv;
  logic [5:0] idx6;
  logic [6:0] idx;

  // output slot free this cycle
  assign adv = !out_valid || out_ready;
  assign pop = !q_empty && (!cur_valid || (adv && k == 2'd3));

  always_comb begin
    case (k)
      2'd0: idx6 = cur.word[23:18];
      2'd1: idx6 = cur.word[17:12];
      2'd2: idx6 = cur.word[11:6];
      default: idx6 = cur.word[5:0];
    endcase
    idx = (k > cur.have) ? b64e_pkg::PadIndex : {1'b0, idx6};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      k <= '0;
    end else begin
      if (adv) begin
        if (cur_valid) begin
          out_valid <= 1'b1;
          out_char <= b64e_pkg::b64_char(idx);
          out_last <= cur.last && (k == 2'd3);
        end else begin
          out_valid <= 1'b0;
        end
      end
      // a queued group loads on the cycle the previous one sends its fourth char, or at once when none is held
      if (pop) begin
        cur <= head;
        cur_valid <= 1'b1;
        k <= '0;
      end else if (adv && cur_valid) begin
        k <= k + 2'd1;
        if (k == 2'd3) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/base64_encoder_unit.sv
// Streaming Base64 encoder, standard alphabet with '=' padding. Bytes enter on
// the slave stream, one per cycle when the group queue has room; tlast on a
// byte ends the message and closes a short group with zero fill and one or two
// pad characters. Characters leave on the master stream one per cycle while
// m_tready is high, and each group of three bytes (or a short final group)
// becomes four characters: the single character register at the output sets
// the sustained rate. A queue of FIFO_DEPTH finished groups sits between
// the byte assembler and the character sequencer so either side can stall.
// tlast on the output marks the final character of a message.
module base64_encoder_unit #(
  parameter int unsigned FIFO_DEPTH = b64e_pkg::FifoDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // last_char
);

  b64e_pkg::group_t push_group;
  b64e_pkg::group_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic [6:0] out_char;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .q_full     (q_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_group (push_group)
  );

  b64e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

FILE: tb/base64_encoder_unit_test.sv
`timescale 1ns / 1ps

module base64_encoder_unit_test;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 12;

  typedef struct {
    logic [6:0] ch;
    logic       lst;
  } char_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       s_tlast = 1'b0;    // last_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [6:0] out_char, [7] zero
  logic       m_tlast;           // last_char

  // predictor state
  logic [15:0] grp_bytes = '0;
  logic [1:0]  grp_cnt = '0;
  char_req_t   pending_chars[$];

  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  bit quiet = 1'b0;   // no idling on either side while set
  int mismatches = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int chars_checked = 0;

  base64_encoder_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  function automatic logic [6:0] b64_ascii(input logic [5:0] idx);
    byte c;
    c = b64_chars[int'(idx)];
    return c[6:0];
  endfunction

  // Expected characters for one accepted byte.
  function automatic void encode_byte(input logic [7:0] b, input logic l);
    logic [23:0] word;
    int have;
    char_req_t r;
    have = int'(grp_cnt) + 1;
    if (have < 3 && !l) begin
      grp_bytes = {grp_bytes[7:0], b};
      grp_cnt = 2'(have);
      return;
    end
    word = {grp_bytes, b} << ((3 - have) * 8);
    for (int k = 0; k < 4; k++) begin
      r.lst = l && (k == 3);
      if (k > have) begin
        r.ch = b64e_pkg::CharPad;
      end else begin
        r.ch = b64_ascii(word[(3 - k) * 6 +: 6]);
      end
      pending_chars.push_back(r);
    end
    grp_bytes = '0;
    grp_cnt = '0;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d characters still expected", $time, pending_chars.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 15);
    end
  end

  // Predict on accepted bytes, then check accepted characters in order.
  always @(posedge clk) begin
    char_req_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        chars_checked++;
        if (pending_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected char: expected none, got %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          e = pending_chars.pop_front();
          if (m_tdata !== {1'b0, e.ch} || m_tlast !== e.lst) begin
            mismatches++;
            $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                     $time, {1'b0, e.ch}, e.lst, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  // Call at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!quiet && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (l) messages_sent++;
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drain();
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One-byte, two-byte and full groups, all-zero / all-one bytes, '+' and '/'.
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // "Man" then "Ma"
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b1);
    s_tvalid <= 1'b0;
    wait_drain();
  endtask

  task automatic test_random_messages();
    while (bytes_sent < 400) begin
      send_message($urandom_range(1, 10));
    end
    s_tvalid <= 1'b0;
    wait_drain();
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_full_rate();
    int start;
    start = bytes_sent;
    quiet = 1'b1;
    while (bytes_sent - start < 60) begin
      send_message($urandom_range(1, 9));
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_messages();
    test_full_rate();
    $display("Encoded %0d bytes in %0d messages, checked %0d output characters.",
             bytes_sent, messages_sent, chars_checked);
    $display("Covered short groups with one and two pad chars, full groups, random stalls.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: base64_encoder_unit.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_encoder_unit.sv
tb/base64_encoder_unit_test.sv
